// ===== hdl/three_phase_sine_pwm_duty_macros.svh =====
// assertion macros shared by the three-phase sine pwm duty modules
// expects a clock named clk and a synchronous active-high reset named rst in scope
`ifndef THREE_PHASE_SINE_PWM_DUTY_MACROS_SVH
`define THREE_PHASE_SINE_PWM_DUTY_MACROS_SVH

// same-cycle implication
`define TPSPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TPSPD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tpspd_pkg.sv =====
// types, constants and the fixed-point sine kernel for the three-phase sine pwm duty block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tpspd_pkg;

  localparam int ANGLE_W   = 32;
  localparam int ELAPSED_W = 16;
  localparam int DUTY_W    = 8;
  localparam int TICKS_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int NUM_DUTY  = 6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_RATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEAD_ANGLE = 2'd2;

  localparam logic [DUTY_W-1:0]    PERIOD_RESET = 8'd255;
  localparam logic [ANGLE_W-1:0]   RATE_RESET   = 32'd684;
  localparam logic [ANGLE_W-1:0]   LEAD_RESET   = 32'd0;

  // phase select codes
  localparam logic [1:0] PH_A = 2'd0;
  localparam logic [1:0] PH_B = 2'd1;
  localparam logic [1:0] PH_C = 2'd2;

  // one turn is 2^32
  localparam logic [ANGLE_W-1:0] THIRD_TURN     = 32'd1431655765;
  localparam logic [ANGLE_W-1:0] TWO_THIRD_TURN = 32'd2863311531;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic       acc_elapsed; // add incoming ticks to elapsed count
    logic       do_mul;      // rate times elapsed
    logic       do_angle;    // trial angle
    logic       issue;       // start one phase lookup
    logic [1:0] sel;         // phase of the lookup
    logic       to_store;    // lookup result goes to the committed duties
    logic       do_cmp;      // compare trial against store, commit on change
    logic       load_out;    // load the output register
  } cmd_t;

  typedef struct packed {
    logic changed;           // some trial duty differs from the store
  } status_t;

  // sine of x quarter turns (Q30), taylor series in nested form, clamped to one
  function automatic logic [30:0] sine_q30(input logic [30:0] x);
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] t;
    logic [63:0] s;
    z  = (64'(x) * HALF_PI_Q30) >> 30;
    z2 = (z * z) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - (((z2 * t) >> 30) / 64'd110);
    t  = Q30_ONE - (((z2 * t) >> 30) / 64'd72);
    t  = Q30_ONE - (((z2 * t) >> 30) / 64'd42);
    t  = Q30_ONE - (((z2 * t) >> 30) / 64'd20);
    t  = Q30_ONE - (((z2 * t) >> 30) / 64'd6);
    s  = (z * t) >> 30;
    if (s > Q30_ONE) begin
      s = Q30_ONE;
    end
    return s[30:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/tpspd_ctrl.sv =====
// controller state machine for the three-phase sine pwm duty block
// depends on tpspd_pkg and three_phase_sine_pwm_duty_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "three_phase_sine_pwm_duty_macros.svh"

module tpspd_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  input  wire tpspd_pkg::status_t status,
  output tpspd_pkg::cmd_t         cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL    = 3'd1;
  localparam logic [2:0] S_ADD    = 3'd2;
  localparam logic [2:0] S_LOOK_T = 3'd3;
  localparam logic [2:0] S_CMP    = 3'd4;
  localparam logic [2:0] S_LOOK_C = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  // three issues, then the lookup pipe drains
  localparam logic [2:0] LOOK_LAST = 3'd4;
  localparam logic [2:0] NUM_ISSUE = 3'd3;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [2:0] cnt;
  logic [2:0] cnt_next;
  logic       out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.acc_elapsed = 1'b1;
          state_next      = S_MUL;
        end
      end
      S_MUL: begin
        cmd.do_mul = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.do_angle = 1'b1;
        cnt_next     = '0;
        state_next   = S_LOOK_T;
      end
      S_LOOK_T, S_LOOK_C: begin
        cmd.issue    = (cnt < NUM_ISSUE);
        cmd.sel      = cnt[1:0];
        cmd.to_store = (state == S_LOOK_C);
        cnt_next     = cnt + 3'd1;
        if (cnt == LOOK_LAST) begin
          state_next = (state == S_LOOK_T) ? S_CMP : S_DONE;
        end
      end
      S_CMP: begin
        cmd.do_cmp = 1'b1;
        cnt_next   = '0;
        state_next = status.changed ? S_LOOK_C : S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `TPSPD_ASSERT_NXT(a_accept_starts, s_tvalid && s_tready, state == S_MUL,
    "accepted transfer did not start the multiply step")
  `TPSPD_ASSERT_IMP(a_cnt_range, state == S_LOOK_T || state == S_LOOK_C, cnt <= LOOK_LAST,
    "lookup counter ran past the pipe drain")
  `TPSPD_ASSERT_IMP(a_out_from_done, $rose(m_tvalid), $past(state) == S_DONE,
    "result shown outside the done step")

endmodule

`default_nettype wire

// ===== hdl/tpspd_dpath.sv =====
// datapath: registers, elapsed count, angle, shared sine lookup pipe and duty store
// depends on tpspd_pkg and three_phase_sine_pwm_duty_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "three_phase_sine_pwm_duty_macros.svh"

module tpspd_dpath #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int SINE_BITS        = 15
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic [tpspd_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  wire logic [tpspd_pkg::ANGLE_W-1:0]         cfg_wdata,
  input  wire logic [tpspd_pkg::TICKS_W-1:0]         ticks,
  input  wire tpspd_pkg::cmd_t                       cmd,
  output tpspd_pkg::status_t                         status,
  output logic [tpspd_pkg::NUM_DUTY*tpspd_pkg::DUTY_W-1:0] out_duty,
  output logic                                       out_updated
);

  localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH);
  localparam int QTR     = SINE_TABLE_DEPTH / 4;
  localparam int QIDX_W  = IDX_W - 1;               // holds 0..QTR
  localparam int QSHIFT  = 30 - (IDX_W - 2);
  localparam int MAG_W   = SINE_BITS + 1;
  localparam int ROM_W   = (QTR + 1) * MAG_W;
  localparam int DSUM_W  = SINE_BITS + 10;
  localparam int DUTY_BIAS = (49 * (2 ** SINE_BITS)) / 100;
  localparam int AW = tpspd_pkg::ANGLE_W;
  localparam int EW = tpspd_pkg::ELAPSED_W;
  localparam int DW = tpspd_pkg::DUTY_W;

  // quarter-wave magnitude table, SINE_BITS fraction bits
  function automatic logic [ROM_W-1:0] build_rom();
    logic [ROM_W-1:0] rom;
    logic [30:0]      s;
    logic [63:0]      m;
    rom = '0;
    for (int i = 0; i <= QTR; i++) begin
      s = tpspd_pkg::sine_q30(31'(i) << QSHIFT);
      m = (64'(s) + (64'd1 << (29 - SINE_BITS))) >> (30 - SINE_BITS);
      if (m > (64'd1 << SINE_BITS)) begin
        m = 64'd1 << SINE_BITS;
      end
      rom[i*MAG_W +: MAG_W] = MAG_W'(m);
    end
    return rom;
  endfunction

  localparam logic [ROM_W-1:0] SINE_ROM = build_rom();

  logic [DW-1:0] pwm_period;
  logic [AW-1:0] phase_rate;
  logic [AW-1:0] lead_angle;

  logic [AW-1:0] phase_accum;
  logic [EW-1:0] elapsed;
  logic [DW-1:0] duty_store [tpspd_pkg::NUM_DUTY];
  logic [DW-1:0] trial      [tpspd_pkg::NUM_DUTY];

  logic [AW-1:0] rate_prod;
  logic [AW-1:0] angle;
  logic [AW-1:0] commit_base;
  logic          updated;

  logic [EW:0]   esum;
  logic [47:0]   mul_full;

  // lookup pipe
  logic              v1;
  logic [1:0]        sel1;
  logic              st1;
  logic [IDX_W-1:0]  idx1;
  logic              v2;
  logic [1:0]        sel2;
  logic              st2;
  logic              neg2;
  logic [MAG_W-1:0]  mag2;

  logic [AW-1:0]     base;
  logic [AW-1:0]     offset;
  logic [AW-1:0]     look_angle;
  logic [QIDX_W-1:0] qoff;
  logic [QIDX_W-1:0] qidx;
  logic [DSUM_W-1:0] dsum;
  logic [DSUM_W-1:0] dshift;
  logic [DW-1:0]     dval;
  logic              diff;

  assign esum     = {1'b0, elapsed} + (EW+1)'(ticks);
  assign mul_full = 48'(phase_rate) * 48'(elapsed);

  always_comb begin
    case (cmd.sel)
      tpspd_pkg::PH_A: offset = '0;
      tpspd_pkg::PH_B: offset = tpspd_pkg::THIRD_TURN;
      tpspd_pkg::PH_C: offset = tpspd_pkg::TWO_THIRD_TURN;
      default:         offset = '0;
    endcase
  end

  assign base       = cmd.to_store ? commit_base : angle;
  assign look_angle = base + offset;

  // odd quadrants run the quarter table backwards
  assign qoff = {1'b0, idx1[IDX_W-3:0]};
  assign qidx = idx1[IDX_W-2] ? (QIDX_W'(QTR) - qoff) : qoff;

  assign dsum   = DSUM_W'(mag2) * DSUM_W'(pwm_period) + DSUM_W'(DUTY_BIAS);
  assign dshift = dsum >> SINE_BITS;
  assign dval   = (dshift > DSUM_W'(255)) ? 8'hFF : dshift[DW-1:0];

  always_comb begin
    diff = 1'b0;
    for (int i = 0; i < tpspd_pkg::NUM_DUTY; i++) begin
      if (trial[i] != duty_store[i]) begin
        diff = 1'b1;
      end
    end
  end
  assign status.changed = diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period  <= tpspd_pkg::PERIOD_RESET;
      phase_rate  <= tpspd_pkg::RATE_RESET;
      lead_angle  <= tpspd_pkg::LEAD_RESET;
      phase_accum <= '0;
      elapsed     <= '0;
      v1          <= 1'b0;
      v2          <= 1'b0;
      for (int i = 0; i < tpspd_pkg::NUM_DUTY; i++) begin
        duty_store[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          tpspd_pkg::REG_PWM_PERIOD: pwm_period <= cfg_wdata[DW-1:0];
          tpspd_pkg::REG_PHASE_RATE: phase_rate <= cfg_wdata;
          tpspd_pkg::REG_LEAD_ANGLE: lead_angle <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.acc_elapsed) begin
        elapsed <= esum[EW] ? {EW{1'b1}} : esum[EW-1:0];
      end
      if (cmd.do_cmp && diff) begin
        phase_accum <= angle;
        elapsed     <= '0;
      end
      v1 <= cmd.issue;
      v2 <= v1;
      if (v2 && st2) begin
        duty_store[{sel2, 1'b0}] <= (mag2 != '0 && !neg2) ? dval : '0;
        duty_store[{sel2, 1'b1}] <= (mag2 != '0 && neg2)  ? dval : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_mul) begin
      rate_prod <= mul_full[AW-1:0];
    end
    if (cmd.do_angle) begin
      angle <= phase_accum + rate_prod;
    end
    if (cmd.do_cmp) begin
      updated     <= diff;
      commit_base <= angle + lead_angle;
    end
    sel1 <= cmd.sel;
    st1  <= cmd.to_store;
    idx1 <= look_angle[AW-1 -: IDX_W];
    sel2 <= sel1;
    st2  <= st1;
    neg2 <= idx1[IDX_W-1];
    mag2 <= SINE_ROM[qidx*MAG_W +: MAG_W];
    if (v2 && !st2) begin
      trial[{sel2, 1'b0}] <= (mag2 != '0 && !neg2) ? dval : '0;
      trial[{sel2, 1'b1}] <= (mag2 != '0 && neg2)  ? dval : '0;
    end
    if (cmd.load_out) begin
      for (int i = 0; i < tpspd_pkg::NUM_DUTY; i++) begin
        out_duty[i*DW +: DW] <= duty_store[i];
      end
      out_updated <= updated;
    end
  end

  `TPSPD_ASSERT_NXT(a_commit_clears, cmd.do_cmp && diff, elapsed == '0,
    "elapsed count not cleared on commit")
  `TPSPD_ASSERT_IMP(a_pipe_order, v2, $past(v1),
    "lookup result without an issued address")
  `TPSPD_ASSERT_IMP(a_issue_order, v1, $past(cmd.issue),
    "lookup address without an issue")

endmodule

`default_nettype wire

// ===== hdl/three_phase_sine_pwm_duty.sv =====
// top level of the three-phase sine pwm duty generator
// depends on tpspd_pkg, tpspd_ctrl and tpspd_dpath
`timescale 1ns / 1ps
`default_nettype none

// Three-phase sinusoidal PWM duty generator. Each input transfer carries the
// timer ticks passed since the previous one; they are added to an elapsed
// count that saturates at 65535. A trial angle, the committed phase plus
// phase_rate times the elapsed count (one turn is 2^32, wrapping), is looked
// up at 0, +120 and +240 degrees in a quarter-wave sine table of
// SINE_TABLE_DEPTH/4+1 entries with SINE_BITS fraction bits, and each phase
// is split into a positive and a negative duty, round(|sine| * pwm_period)
// with a 0.49 count bias on the side of the sign and zero on the other. If
// any trial duty differs from the stored ones the phase advances to the trial
// angle, the elapsed count clears and the stored duties are recomputed at the
// new phase plus lead_angle; updated is then 1. Every input transfer yields
// exactly one output transfer with the stored duties. The steps are one
// multiply and one add for the angle, the shared lookup pipe for the trial
// duties (three phase issues, then draining the table read and duty
// multiply), one compare, a second lookup pass for the stored duties when
// they are recommitted, and one output load. The next input is accepted from
// the cycle after the output load. One item is in the datapath at a time; a
// finished result waits in the output register and the next input is
// accepted meanwhile. SINE_TABLE_DEPTH must be a power of two. The user must
// write registers only while no item is in flight; the block itself does not
// enforce this.
module three_phase_sine_pwm_duty #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int SINE_BITS        = 15
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration: 0 pwm_period, 1 phase_rate, 2 lead_angle
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [31:0] cfg_wdata,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] ticks_elapsed
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // [7:0] duty_a_pos, [15:8] duty_a_neg,
                                      // [23:16] duty_b_pos, [31:24] duty_b_neg,
                                      // [39:32] duty_c_pos, [47:40] duty_c_neg
  output logic [0:0]       m_tuser    // [0] updated
);

  tpspd_pkg::cmd_t    cmd;
  tpspd_pkg::status_t status;
  logic               out_updated;

  // sequencing: accept, angle, trial lookups, compare, commit lookups, output
  tpspd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // registers, phase state, shared sine lookup and the duty store
  tpspd_dpath #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .SINE_BITS        (SINE_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .ticks       (s_tdata),
    .cmd         (cmd),
    .status      (status),
    .out_duty    (m_tdata),
    .out_updated (out_updated)
  );

  assign m_tuser = out_updated;

endmodule

`default_nettype wire
